FILE: sv/bezier_curve_point_eval_macros.svh
// Assertion macros shared by the block
`ifndef BEZIER_CURVE_POINT_EVAL_MACROS_SVH
`define BEZIER_CURVE_POINT_EVAL_MACROS_SVH

`define BCPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define BCPE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

FILE: sv/bcpe_pkg.sv
package bcpe_pkg;

  localparam int CoordW       = 24;
  localparam int DiffW        = CoordW + 1;
  localparam int TW           = 16;
  localparam int UnitW        = 16;
  localparam int CountW       = 6;
  localparam int MaxPointsDef = 32;
  localparam int TOne         = 32768;
  localparam int MagW         = 15;
  localparam int Len2W        = 2 * MagW + 1;
  localparam int RootW        = 16;
  localparam int DivSteps     = Len2W;
  localparam int SqrtSteps    = RootW;
  localparam int StepW        = 5;

  typedef enum logic [1:0] {
    ModeAppend = 2'd0,
    ModeClear  = 2'd1,
    ModeEval   = 2'd2,
    ModeNone   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    StIdle,
    StExec,
    StLvlRd,
    StDrain,
    StNrmLoad,
    StNrmShift,
    StNrmSq,
    StDivInit,
    StDiv,
    StSqrtInit,
    StSqrt,
    StUnit,
    StResult
  } state_e;

  typedef struct packed {
    logic load_item;
    logic clr_res;
    logic append;
    logic clear;
    logic rd_en;
    logic rd_store;
    logic rd_first;
    logic rd_final;
    logic rd_single;
    logic nrm_load;
    logic nrm_shift;
    logic nrm_square;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic unit_store;
    logic axis;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  num_zero;
    logic  need_shift;
    logic  dir_zero;
    logic  out_free;
  } sts_t;

endpackage

FILE: sv/bezier_curve_point_eval.sv
// Bezier curve point evaluator with a store of up to MAX_POINTS control points.
// Input channel s_axis: tuser carries the mode (append, clear, evaluate), tdata
// the point coordinates and the parameter t. One result beat per input beat on
// m_axis: tuser carries the reject flag, tdata the curve point, the unit tangent,
// the normal and the point count after the item.
// Append, clear and unused modes go from the execute state straight to the result.
// An evaluation over n points runs de Casteljau on one shared pair of
// interpolators, fed from the point store at the first level and from the
// work memory after it, one point per cycle per level; then normalisation
// (up to 10 shift steps, a 31-step divider and a 16-step square root per axis).
// One item is in flight at a time.
// Reset empties the store (count to zero) and drops any pending result.
// The result register holds a finished beat while m_axis_tready is low; the
// next item is accepted and worked on meanwhile, and waits only to hand over.
module bezier_curve_point_eval #(
  parameter int MAX_POINTS = bcpe_pkg::MaxPointsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // point_x[23:0], point_y[47:24], param_t[63:48]
  input  logic [1:0]   s_axis_tuser,  // mode[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,  // pos_x, pos_y, tangent_x, tangent_y,
                                      // normal_x, normal_y, point_count, zero pad
  output logic [0:0]   m_axis_tuser   // status
);

  `include "bezier_curve_point_eval_macros.svh"

  localparam int IdxW = $clog2(MAX_POINTS);
  localparam int CntW = $clog2(MAX_POINTS + 1);

  bcpe_pkg::cmd_t  cmd;
  bcpe_pkg::sts_t  sts;
  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] num;
  logic            out_status;
  logic [bcpe_pkg::CoordW-1:0] pos_x, pos_y;
  logic [bcpe_pkg::UnitW-1:0]  tan_x, tan_y, nrm_x, nrm_y;
  logic [bcpe_pkg::CountW-1:0] count;
  logic            res_zero;

  bcpe_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .IdxW       (IdxW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .num_i      (num),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  bcpe_dp #(
    .MAX_POINTS (MAX_POINTS),
    .IdxW       (IdxW),
    .CntW       (CntW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .rd_addr_i    (rd_addr),
    .in_mode_i    (s_axis_tuser),
    .in_x_i       (s_axis_tdata[23:0]),
    .in_y_i       (s_axis_tdata[47:24]),
    .in_t_i       (s_axis_tdata[63:48]),
    .sts_o        (sts),
    .num_o        (num),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_pos_x_o  (pos_x),
    .out_pos_y_o  (pos_y),
    .out_tan_x_o  (tan_x),
    .out_tan_y_o  (tan_y),
    .out_nrm_x_o  (nrm_x),
    .out_nrm_y_o  (nrm_y),
    .out_count_o  (count)
  );

  assign m_axis_tdata = {2'b00, count, nrm_y, nrm_x, tan_y, tan_x, pos_y, pos_x};
  assign m_axis_tuser = out_status;
  assign res_zero     = (m_axis_tdata[111:0] == '0);

  `BCPE_ASSERT(a_count_bound, num <= CntW'(MAX_POINTS), "point count above store size")
  `BCPE_ASSERT(a_reject_zero, (m_axis_tvalid && out_status) |-> res_zero, "reject not zero")
  `BCPE_ASSERT(a_normal, m_axis_tvalid |-> (nrm_y == tan_x && nrm_x == -tan_y), "bad normal")
  `BCPE_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item taken busy")

endmodule

FILE: sv/bcpe_ctrl.sv
module bcpe_ctrl #(
  parameter int MAX_POINTS = bcpe_pkg::MaxPointsDef,
  parameter int IdxW       = $clog2(MAX_POINTS),
  parameter int CntW       = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bcpe_pkg::sts_t   sts_i,
  input  logic [CntW-1:0]  num_i,
  output bcpe_pkg::cmd_t   cmd_o,
  output logic [IdxW-1:0]  rd_addr_o
);

  bcpe_pkg::state_e state_q, state_d;
  logic [CntW-1:0]           lvl_q, lvl_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [bcpe_pkg::StepW-1:0] step_q, step_d;
  logic                      drain_q, drain_d;
  logic                      src_q, src_d;
  logic                      axis_q, axis_d;
  logic [CntW-1:0]           last_idx;

  assign last_idx = lvl_q - CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcpe_pkg::StIdle;
      lvl_q   <= '0;
      idx_q   <= '0;
      step_q  <= '0;
      drain_q <= 1'b0;
      src_q   <= 1'b0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      drain_q <= drain_d;
      src_q   <= src_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    lvl_d      = lvl_q;
    idx_d      = idx_q;
    step_d     = step_q;
    drain_d    = drain_q;
    src_d      = src_q;
    axis_d     = axis_q;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    in_ready_o = 1'b0;
    rd_addr_o  = idx_q;
    case (state_q)
      bcpe_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cmd_o.clr_res   = 1'b1;
          state_d         = bcpe_pkg::StExec;
        end
      end
      bcpe_pkg::StExec: begin
        case (sts_i.mode)
          bcpe_pkg::ModeAppend: begin
            cmd_o.append = 1'b1;
            state_d      = bcpe_pkg::StResult;
          end
          bcpe_pkg::ModeClear: begin
            cmd_o.clear = 1'b1;
            state_d     = bcpe_pkg::StResult;
          end
          bcpe_pkg::ModeEval: begin
            if (sts_i.num_zero) begin
              state_d = bcpe_pkg::StResult;
            end else begin
              lvl_d   = num_i;
              idx_d   = '0;
              src_d   = 1'b1;
              state_d = bcpe_pkg::StLvlRd;
            end
          end
          default: state_d = bcpe_pkg::StResult;
        endcase
      end
      bcpe_pkg::StLvlRd: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_store  = src_q;
        cmd_o.rd_first  = (idx_q == '0);
        cmd_o.rd_final  = (lvl_q == CntW'(2));
        cmd_o.rd_single = (lvl_q == CntW'(1));
        if (CntW'(idx_q) == last_idx) begin
          idx_d   = '0;
          drain_d = 1'b0;
          state_d = bcpe_pkg::StDrain;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      bcpe_pkg::StDrain: begin
        drain_d = 1'b1;
        if (drain_q) begin
          if (lvl_q == CntW'(1)) begin
            state_d = bcpe_pkg::StResult;
          end else if (lvl_q == CntW'(2)) begin
            state_d = bcpe_pkg::StNrmLoad;
          end else begin
            lvl_d   = last_idx;
            src_d   = 1'b0;
            state_d = bcpe_pkg::StLvlRd;
          end
        end
      end
      bcpe_pkg::StNrmLoad: begin
        cmd_o.nrm_load = 1'b1;
        state_d        = bcpe_pkg::StNrmShift;
      end
      bcpe_pkg::StNrmShift: begin
        if (sts_i.dir_zero) begin
          state_d = bcpe_pkg::StResult;
        end else if (sts_i.need_shift) begin
          cmd_o.nrm_shift = 1'b1;
        end else begin
          state_d = bcpe_pkg::StNrmSq;
        end
      end
      bcpe_pkg::StNrmSq: begin
        cmd_o.nrm_square = 1'b1;
        axis_d           = 1'b0;
        state_d          = bcpe_pkg::StDivInit;
      end
      bcpe_pkg::StDivInit: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = bcpe_pkg::StDiv;
      end
      bcpe_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + bcpe_pkg::StepW'(1);
        if (step_q == bcpe_pkg::StepW'(bcpe_pkg::DivSteps - 1)) begin
          state_d = bcpe_pkg::StSqrtInit;
        end
      end
      bcpe_pkg::StSqrtInit: begin
        cmd_o.sqrt_init = 1'b1;
        step_d          = '0;
        state_d         = bcpe_pkg::StSqrt;
      end
      bcpe_pkg::StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        step_d          = step_q + bcpe_pkg::StepW'(1);
        if (step_q == bcpe_pkg::StepW'(bcpe_pkg::SqrtSteps - 1)) begin
          state_d = bcpe_pkg::StUnit;
        end
      end
      bcpe_pkg::StUnit: begin
        cmd_o.unit_store = 1'b1;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = bcpe_pkg::StDivInit;
        end else begin
          state_d = bcpe_pkg::StResult;
        end
      end
      bcpe_pkg::StResult: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = bcpe_pkg::StIdle;
        end
      end
      default: state_d = bcpe_pkg::StIdle;
    endcase
  end

endmodule

FILE: sv/bcpe_dp.sv
module bcpe_dp #(
  parameter int MAX_POINTS = bcpe_pkg::MaxPointsDef,
  parameter int IdxW       = $clog2(MAX_POINTS),
  parameter int CntW       = $clog2(MAX_POINTS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bcpe_pkg::cmd_t               cmd_i,
  input  logic [IdxW-1:0]              rd_addr_i,
  input  logic [1:0]                   in_mode_i,
  input  logic [bcpe_pkg::CoordW-1:0]  in_x_i,
  input  logic [bcpe_pkg::CoordW-1:0]  in_y_i,
  input  logic [bcpe_pkg::TW-1:0]      in_t_i,
  output bcpe_pkg::sts_t               sts_o,
  output logic [CntW-1:0]              num_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         out_status_o,
  output logic [bcpe_pkg::CoordW-1:0]  out_pos_x_o,
  output logic [bcpe_pkg::CoordW-1:0]  out_pos_y_o,
  output logic [bcpe_pkg::UnitW-1:0]   out_tan_x_o,
  output logic [bcpe_pkg::UnitW-1:0]   out_tan_y_o,
  output logic [bcpe_pkg::UnitW-1:0]   out_nrm_x_o,
  output logic [bcpe_pkg::UnitW-1:0]   out_nrm_y_o,
  output logic [bcpe_pkg::CountW-1:0]  out_count_o
);

  localparam int CW  = bcpe_pkg::CoordW;
  localparam int DW  = bcpe_pkg::DiffW;
  localparam int PW  = DW + bcpe_pkg::TW + 1;
  localparam int MW  = bcpe_pkg::MagW;
  localparam int LW  = bcpe_pkg::Len2W;
  localparam int RW  = bcpe_pkg::RootW;
  localparam int UW  = bcpe_pkg::UnitW;

  logic [1:0]           mode_q;
  logic [bcpe_pkg::TW-1:0] t_q;
  logic [CW-1:0]        ix_q, iy_q;
  logic [CntW-1:0]      num_q;
  logic                 status_q;
  logic                 full;

  logic [CW-1:0] st_x_mem [MAX_POINTS];
  logic [CW-1:0] st_y_mem [MAX_POINTS];
  logic [CW-1:0] wk_x_mem [MAX_POINTS];
  logic [CW-1:0] wk_y_mem [MAX_POINTS];
  logic [CW-1:0] srd_x_q, srd_y_q, wrd_x_q, wrd_y_q;

  logic            a_vld_q, a_first_q, a_store_q, a_final_q, a_single_q;
  logic [IdxW-1:0] a_idx_q;
  logic signed [CW-1:0] rx, ry, prev_x_q, prev_y_q;

  logic            b_vld_q, b_final_q;
  logic [IdxW-1:0] b_wa_q;
  logic signed [CW-1:0] base_x_q, base_y_q;
  logic signed [PW-1:0] prod_x_q, prod_y_q;
  logic signed [PW-1:0] rnd_x, rnd_y, sh_x, sh_y;
  logic signed [CW-1:0] val_x, val_y;

  logic signed [CW-1:0] pos_x_q, pos_y_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic [DW-1:0]        ax_q, ay_q;
  logic                 sx_q, sy_q;
  logic [LW-1:0]        len2_q;

  logic [MW-1:0]        amag;
  logic [2*MW-1:0]      asq;
  logic [LW-1:0]        rem_q, quo_q;
  logic                 dbit_q;
  logic [LW:0]          r2;

  logic [LW:0]          sq_src_q;
  logic [RW+1:0]        srem_q;
  logic [RW-1:0]        root_q;
  logic [RW+3:0]        srem2, trial;

  logic [RW:0]          root_inc;
  logic [UW-1:0]        umag, usgn;
  logic signed [UW-1:0] tx_q, ty_q;

  logic                 out_valid_q, out_status_q;
  logic [CW-1:0]        out_px_q, out_py_q;
  logic [UW-1:0]        out_tx_q, out_ty_q;
  logic [bcpe_pkg::CountW-1:0] out_cnt_q;
  logic [CntW+bcpe_pkg::CountW-1:0] cnt_ext;

  assign full = (num_q >= CntW'(MAX_POINTS));

  // Item and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q    <= '0;
      status_q <= 1'b0;
      mode_q   <= bcpe_pkg::ModeNone;
    end else begin
      if (cmd_i.load_item) begin
        mode_q <= in_mode_i;
      end
      if (cmd_i.clr_res) begin
        status_q <= 1'b0;
      end
      if (cmd_i.append) begin
        status_q <= full;
        if (!full) begin
          num_q <= num_q + CntW'(1);
        end
      end
      if (cmd_i.clear) begin
        num_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      ix_q <= in_x_i;
      iy_q <= in_y_i;
      t_q  <= (in_t_i > bcpe_pkg::TW'(bcpe_pkg::TOne)) ? bcpe_pkg::TW'(bcpe_pkg::TOne) : in_t_i;
    end
  end

  // Control point store
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      st_x_mem[num_q[IdxW-1:0]] <= ix_q;
      st_y_mem[num_q[IdxW-1:0]] <= iy_q;
    end
    if (cmd_i.rd_en) begin
      srd_x_q <= st_x_mem[rd_addr_i];
      srd_y_q <= st_y_mem[rd_addr_i];
    end
  end

  // Work store
  always_ff @(posedge clk_i) begin
    if (b_vld_q && !b_final_q) begin
      wk_x_mem[b_wa_q] <= val_x;
      wk_y_mem[b_wa_q] <= val_y;
    end
    if (cmd_i.rd_en) begin
      wrd_x_q <= wk_x_mem[rd_addr_i];
      wrd_y_q <= wk_y_mem[rd_addr_i];
    end
  end

  assign rx = a_store_q ? srd_x_q : wrd_x_q;
  assign ry = a_store_q ? srd_y_q : wrd_y_q;

  assign rnd_x = prod_x_q + PW'(16384);
  assign rnd_y = prod_y_q + PW'(16384);
  assign sh_x  = rnd_x >>> 15;
  assign sh_y  = rnd_y >>> 15;
  assign val_x = base_x_q + sh_x[CW-1:0];
  assign val_y = base_y_q + sh_y[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= cmd_i.rd_en;
      b_vld_q <= a_vld_q && !a_first_q;
    end
  end

  // Interpolation pipeline
  always_ff @(posedge clk_i) begin
    a_first_q  <= cmd_i.rd_first;
    a_store_q  <= cmd_i.rd_store;
    a_final_q  <= cmd_i.rd_final;
    a_single_q <= cmd_i.rd_single;
    a_idx_q    <= rd_addr_i;
    if (a_vld_q) begin
      prev_x_q  <= rx;
      prev_y_q  <= ry;
      base_x_q  <= prev_x_q;
      base_y_q  <= prev_y_q;
      prod_x_q  <= PW'(DW'(rx) - DW'(prev_x_q)) * $signed({1'b0, t_q});
      prod_y_q  <= PW'(DW'(ry) - DW'(prev_y_q)) * $signed({1'b0, t_q});
      b_wa_q    <= a_idx_q - IdxW'(1);
      b_final_q <= a_final_q;
      if (a_final_q && !a_first_q) begin
        dx_q <= DW'(prev_x_q) - DW'(rx);
        dy_q <= DW'(prev_y_q) - DW'(ry);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_res) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else if (a_vld_q && a_single_q) begin
      pos_x_q <= rx;
      pos_y_q <= ry;
    end else if (b_vld_q && b_final_q) begin
      pos_x_q <= val_x;
      pos_y_q <= val_y;
    end
  end

  // Normalisation
  assign amag = cmd_i.axis ? ay_q[MW-1:0] : ax_q[MW-1:0];
  assign asq  = amag * amag;
  assign r2   = {rem_q, dbit_q};

  assign srem2 = {srem_q, sq_src_q[LW:LW-1]};
  assign trial = {2'b00, root_q, 2'b01};

  assign root_inc = {1'b0, root_q} + (RW+1)'(1);
  assign umag     = UW'(root_inc >> 1);
  assign usgn     = (cmd_i.axis ? sy_q : sx_q) ? (UW'(0) - umag) : umag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.nrm_load) begin
      sx_q <= dx_q[DW-1];
      sy_q <= dy_q[DW-1];
      ax_q <= dx_q[DW-1] ? (DW'(0) - dx_q) : dx_q;
      ay_q <= dy_q[DW-1] ? (DW'(0) - dy_q) : dy_q;
    end else if (cmd_i.nrm_shift) begin
      ax_q <= ax_q >> 1;
      ay_q <= ay_q >> 1;
    end
    if (cmd_i.nrm_square) begin
      len2_q <= LW'(ax_q[MW-1:0] * ax_q[MW-1:0]) + LW'(ay_q[MW-1:0] * ay_q[MW-1:0]);
    end
    if (cmd_i.div_init) begin
      rem_q  <= LW'(asq >> 1);
      dbit_q <= asq[0];
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      dbit_q <= 1'b0;
      if (r2 >= {1'b0, len2_q}) begin
        rem_q <= LW'(r2 - {1'b0, len2_q});
        quo_q <= {quo_q[LW-2:0], 1'b1};
      end else begin
        rem_q <= r2[LW-1:0];
        quo_q <= {quo_q[LW-2:0], 1'b0};
      end
    end
    if (cmd_i.sqrt_init) begin
      sq_src_q <= {1'b0, quo_q};
      srem_q   <= '0;
      root_q   <= '0;
    end else if (cmd_i.sqrt_step) begin
      sq_src_q <= {sq_src_q[LW-2:0], 2'b00};
      if (srem2 >= trial) begin
        srem_q <= (RW+2)'(srem2 - trial);
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        srem_q <= srem2[RW+1:0];
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
    if (cmd_i.clr_res) begin
      tx_q <= '0;
      ty_q <= '0;
    end else if (cmd_i.unit_store) begin
      if (cmd_i.axis) begin
        ty_q <= usgn;
      end else begin
        tx_q <= usgn;
      end
    end
  end

  // Output register
  assign cnt_ext = {{bcpe_pkg::CountW{1'b0}}, num_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_px_q     <= pos_x_q;
      out_py_q     <= pos_y_q;
      out_tx_q     <= tx_q;
      out_ty_q     <= ty_q;
      out_cnt_q    <= cnt_ext[bcpe_pkg::CountW-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_pos_x_o  = out_px_q;
  assign out_pos_y_o  = out_py_q;
  assign out_tan_x_o  = out_tx_q;
  assign out_tan_y_o  = out_ty_q;
  assign out_nrm_x_o  = UW'(0) - out_ty_q;
  assign out_nrm_y_o  = out_tx_q;
  assign out_count_o  = out_cnt_q;

  assign sts_o.mode       = bcpe_pkg::mode_e'(mode_q);
  assign sts_o.num_zero   = (num_q == '0);
  assign sts_o.need_shift = (|ax_q[DW-1:MW]) || (|ay_q[DW-1:MW]);
  assign sts_o.dir_zero   = (ax_q == '0) && (ay_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign num_o            = num_q;

endmodule
